/* rtl/int64_divide_remainder_unit_macros.svh */
// Assertion macros shared by the divider checker.
// Depends on nothing; include by bare file name.
`ifndef INT64_DIVIDE_REMAINDER_UNIT_MACROS_SVH
`define INT64_DIVIDE_REMAINDER_UNIT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define DIV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DIV_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/idr_pkg.sv */
// Types and constants of the 64-bit divide/remainder unit.
// Used by every module of the unit; depends on nothing.
package idr_pkg;
  localparam int DATA_WIDTH = 64;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef enum logic [1:0] {
    OP_DIVU = 2'd0,
    OP_REMU = 2'd1,
    OP_DIV  = 2'd2,
    OP_REM  = 2'd3
  } op_t;

  typedef struct packed {
    logic want_rem;
    logic neg_quo;
    logic neg_rem;
    logic zero_den;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    word_t part;
    word_t num;
    word_t den;
    word_t quo;
  } stage_t;
endpackage

/* rtl/idr_prep.sv */
// Input stage: reduce signed operands to magnitudes and record sign fixes.
// Depends on idr_pkg.
module idr_prep import idr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   in_valid,
  input  logic [1:0] operation,
  input  word_t  dividend,
  input  word_t  divisor,
  output logic   out_valid,
  output stage_t out_data
);
  logic signed_op, num_neg, den_neg;
  stage_t data_next;

  always_comb begin
    signed_op = operation[1];
    num_neg = signed_op & dividend[DATA_WIDTH-1];
    den_neg = signed_op & divisor[DATA_WIDTH-1];
    data_next.ctl.want_rem = operation[0];
    data_next.ctl.neg_quo = num_neg ^ den_neg;
    data_next.ctl.neg_rem = num_neg;
    data_next.ctl.zero_den = (divisor == '0);
    data_next.part = '0;
    data_next.quo = '0;
    data_next.num = num_neg ? (~dividend + word_t'(1)) : dividend;
    data_next.den = den_neg ? (~divisor + word_t'(1)) : divisor;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= data_next;
    end
  end
endmodule

/* rtl/idr_step.sv */
// One restoring shift-subtract stage: takes the top dividend bit, shifts in one quotient bit.
// Depends on idr_pkg.
module idr_step import idr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output stage_t out_data
);
  logic [DATA_WIDTH:0] shifted, diff;
  stage_t data_next;

  always_comb begin
    shifted = {in_data.part, in_data.num[DATA_WIDTH-1]};
    diff = shifted - {1'b0, in_data.den};
    data_next = in_data;
    data_next.num = {in_data.num[DATA_WIDTH-2:0], 1'b0};
    if (!diff[DATA_WIDTH]) begin
      data_next.part = diff[DATA_WIDTH-1:0];
      data_next.quo = {in_data.quo[DATA_WIDTH-2:0], 1'b1};
    end else begin
      data_next.part = shifted[DATA_WIDTH-1:0];
      data_next.quo = {in_data.quo[DATA_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      out_data <= data_next;
    end
  end
endmodule

/* rtl/idr_fix.sv */
// Output stage: select quotient or remainder, apply signs and zero divisor.
// Depends on idr_pkg.
module idr_fix import idr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   advance,
  input  logic   in_valid,
  input  stage_t in_data,
  output logic   out_valid,
  output word_t  result
);
  word_t pick, res_next;
  logic  neg;

  always_comb begin
    pick = in_data.ctl.want_rem ? in_data.part : in_data.quo;
    neg = in_data.ctl.want_rem ? in_data.ctl.neg_rem : in_data.ctl.neg_quo;
    res_next = neg ? (~pick + word_t'(1)) : pick;
    if (in_data.ctl.zero_den) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (advance) begin
      result <= res_next;
    end
  end
endmodule

/* rtl/int64_divide_remainder_unit.sv */
// Top level of the 64-bit divide/remainder unit.
// Depends on idr_pkg, idr_prep, idr_step and idr_fix.
//
// Fully pipelined 64-bit divider: one beat enters every cycle while the pipe
// is not stalled, and its result reaches the output through the 66 register
// stages (one operand stage, one restoring shift-subtract stage per quotient
// bit, one sign/select stage). The whole pipe stalls together while the
// output beat is held, bubbles included, so ready is high whenever the last
// stage is empty or being taken. Operations: unsigned/signed quotient and
// remainder; a zero divisor returns 0.
module int64_divide_remainder_unit import idr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  word_t       dividend,
  input  word_t       divisor,
  output logic        out_valid,
  input  logic        out_ready,
  output word_t       result
);
  logic   v [DATA_WIDTH+1];
  stage_t d [DATA_WIDTH+1];
  logic   advance;

  assign advance = out_ready | ~out_valid;
  assign in_ready = advance;

  idr_prep u_prep (
    .clk, .rst, .advance,
    .in_valid (in_valid), .operation, .dividend, .divisor,
    .out_valid (v[0]), .out_data (d[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_step
    idr_step u_step (
      .clk, .rst, .advance,
      .in_valid (v[i]), .in_data (d[i]),
      .out_valid (v[i+1]), .out_data (d[i+1])
    );
  end

  idr_fix u_fix (
    .clk, .rst, .advance,
    .in_valid (v[DATA_WIDTH]), .in_data (d[DATA_WIDTH]),
    .out_valid, .result
  );
endmodule

/* rtl/idr_checker.sv */
// Port-level checker for the divide/remainder unit, bound to the top level.
// Depends on idr_pkg and int64_divide_remainder_unit_macros.svh.
`include "int64_divide_remainder_unit_macros.svh"
module idr_checker import idr_pkg::*; (
  input logic  clk,
  input logic  rst,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t result
);
  `DIV_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(result), "output beat dropped or changed while stalled")
  `DIV_ASSERT(a_ready_stall, in_ready == (out_ready || !out_valid), "input ready does not follow output stall")
  `DIV_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")
endmodule

bind int64_divide_remainder_unit idr_checker u_idr_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .result
);
